// File: hdl/rsc_pkg.sv
// Shared types, constants and word functions for the reduced-width SHA-256 pair check.
// No dependencies; imported by every module of the block.
package rsc_pkg;

    localparam int WORD_BITS = 19;
    localparam int ROUNDS    = 57;
    localparam int MSG_WORDS = 16;
    localparam int CNT_BITS  = $clog2(ROUNDS + 1);

    typedef logic [WORD_BITS-1:0] t_word;
    typedef logic [CNT_BITS-1:0]  t_round;

    typedef struct packed {
        logic load;
        logic step;
    } t_lane_ctrl;

    localparam t_word TOP_BIT = t_word'(1) << (WORD_BITS - 1);

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] INIT_H [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    // round(k*WORD_BITS/32), half to even, at least 1
    function automatic int scaled(input int k);
        int p;
        int q;
        int r;
        p = k * WORD_BITS;
        q = p / 32;
        r = p % 32;
        if (r > 16 || (r == 16 && (q % 2) == 1)) begin
            q = q + 1;
        end
        return (q < 1) ? 1 : q;
    endfunction

    localparam int S0A = scaled(7);
    localparam int S0B = scaled(18);
    localparam int S0C = scaled(3);
    localparam int S1A = scaled(17);
    localparam int S1B = scaled(19);
    localparam int S1C = scaled(10);
    localparam int E0A = scaled(2);
    localparam int E0B = scaled(13);
    localparam int E0C = scaled(22);
    localparam int E1A = scaled(6);
    localparam int E1B = scaled(11);
    localparam int E1C = scaled(25);

    function automatic t_word rotr(input t_word x, input int k);
        int kk;
        kk = k % WORD_BITS;
        if (kk == 0) begin
            return x;
        end
        return (x >> kk) | (x << (WORD_BITS - kk));
    endfunction

    function automatic t_word round_k(input t_round idx);
        logic [5:0] i6;
        i6 = 6'(idx);
        return ROUND_K[i6][WORD_BITS-1:0];
    endfunction

    function automatic t_word init_h(input int i);
        return INIT_H[i][WORD_BITS-1:0];
    endfunction

endpackage

// File: hdl/rsc_cell.sv
// One message-schedule cell: holds one word, loads it or takes its neighbor's each round.
// Depends on rsc_pkg.
module rsc_cell (
    input  logic               i_clk,
    input  rsc_pkg::t_lane_ctrl i_ctrl,
    input  rsc_pkg::t_word     i_load_word,
    input  rsc_pkg::t_word     i_shift_word,
    output rsc_pkg::t_word     o_word
);
    import rsc_pkg::*;

    t_word r_word;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_word <= i_load_word;
        end else if (i_ctrl.step) begin
            r_word <= i_shift_word;
        end
    end

    assign o_word = r_word;

endmodule

// File: hdl/rsc_lane.sv
// One compression lane: a chain of 16 schedule cells feeding a one-round-per-cycle round unit.
// Depends on rsc_pkg and rsc_cell.
module rsc_lane (
    input  logic                i_clk,
    input  rsc_pkg::t_lane_ctrl i_ctrl,
    input  rsc_pkg::t_word      i_word0,
    input  rsc_pkg::t_word      i_word9,
    input  rsc_pkg::t_word      i_fill,
    input  rsc_pkg::t_word      i_k,
    output rsc_pkg::t_word      o_a
);
    import rsc_pkg::*;

    t_word win [MSG_WORDS];
    t_word shift_in [MSG_WORDS];
    t_word load_in [MSG_WORDS];
    t_word sig0;
    t_word sig1;
    t_word w_new;

    t_word r_a, r_b, r_c, r_d, r_e, r_f, r_g, r_h;
    t_word big0, big1, ch, maj, t1, t2;

    // window holds w[i .. i+15]; new word is w[i+16]
    assign sig1  = rotr(win[14], S1A) ^ rotr(win[14], S1B) ^ (win[14] >> S1C);
    assign sig0  = rotr(win[1], S0A) ^ rotr(win[1], S0B) ^ (win[1] >> S0C);
    assign w_new = sig1 + win[9] + sig0 + win[0];

    genvar j;
    generate
        for (j = 0; j < MSG_WORDS; j++) begin : g_cell
            if (j == MSG_WORDS - 1) begin : g_tail
                assign shift_in[j] = w_new;
            end else begin : g_body
                assign shift_in[j] = win[j+1];
            end
            if (j == 0) begin : g_w0
                assign load_in[j] = i_word0;
            end else if (j == 9) begin : g_w9
                assign load_in[j] = i_word9;
            end else begin : g_wf
                assign load_in[j] = i_fill;
            end
            rsc_cell u_cell (
                .i_clk        (i_clk),
                .i_ctrl       (i_ctrl),
                .i_load_word  (load_in[j]),
                .i_shift_word (shift_in[j]),
                .o_word       (win[j])
            );
        end
    endgenerate

    assign big1 = rotr(r_e, E1A) ^ rotr(r_e, E1B) ^ rotr(r_e, E1C);
    assign ch   = (r_e & r_f) ^ (~r_e & r_g);
    assign t1   = r_h + big1 + ch + i_k + win[0];
    assign big0 = rotr(r_a, E0A) ^ rotr(r_a, E0B) ^ rotr(r_a, E0C);
    assign maj  = (r_a & r_b) ^ (r_a & r_c) ^ (r_b & r_c);
    assign t2   = big0 + maj;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_a <= init_h(0);
            r_b <= init_h(1);
            r_c <= init_h(2);
            r_d <= init_h(3);
            r_e <= init_h(4);
            r_f <= init_h(5);
            r_g <= init_h(6);
            r_h <= init_h(7);
        end else if (i_ctrl.step) begin
            r_h <= r_g;
            r_g <= r_f;
            r_f <= r_e;
            r_e <= r_d + t1;
            r_d <= r_c;
            r_c <= r_b;
            r_b <= r_a;
            r_a <= t1 + t2;
        end
    end

    assign o_a = r_a;

endmodule

// File: hdl/reduced_sha256_pair_check.sv
// Top level of the reduced-width SHA-256 pair check: control, two lanes, result register.
// Depends on rsc_pkg and rsc_lane.
//
// Each beat carries a candidate word 0 and a fill word. Two 19-bit SHA-256 compressions run
// side by side, one on the plain message and one with the top bit flipped in words 0 and 9,
// each through 57 rounds; the beat out gives both final a words and their equality. An
// item passes through the accept, the rounds of the single round unit in each lane (one
// round per cycle, schedule words marching down a 16-cell chain) and the capture of the
// result, which waits while an earlier result is still unaccepted. The input is taken only
// while no item is in flight; a waiting result does not block the next accept.
module reduced_sha256_pair_check (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  rsc_pkg::t_word i_first_word,
    input  rsc_pkg::t_word i_fill_word,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output rsc_pkg::t_word o_a_plain,
    output rsc_pkg::t_word o_a_flipped,
    output logic           o_match
);
    import rsc_pkg::*;

    typedef enum logic {S_IDLE, S_RUN} t_state;

    t_state     r_state;
    t_round     r_round;
    logic       r_out_valid;
    t_word      r_a_plain;
    t_word      r_a_flipped;
    logic       r_match;

    t_lane_ctrl ctrl;
    t_word      k_word;
    t_word      a_plain;
    t_word      a_flipped;
    logic       in_beat;
    logic       rounds_done;
    logic       out_free;
    logic       out_load;

    assign in_beat     = i_in_valid && (r_state == S_IDLE);
    assign rounds_done = (r_round == t_round'(ROUNDS));
    assign out_free    = !r_out_valid || i_out_ready;
    assign out_load    = (r_state == S_RUN) && rounds_done && out_free;
    assign ctrl.load   = in_beat;
    assign ctrl.step   = (r_state == S_RUN) && !rounds_done;
    assign k_word      = round_k(r_round);

    rsc_lane u_lane_plain (
        .i_clk   (i_clk),
        .i_ctrl  (ctrl),
        .i_word0 (i_first_word),
        .i_word9 (i_fill_word),
        .i_fill  (i_fill_word),
        .i_k     (k_word),
        .o_a     (a_plain)
    );

    rsc_lane u_lane_flipped (
        .i_clk   (i_clk),
        .i_ctrl  (ctrl),
        .i_word0 (i_first_word ^ TOP_BIT),
        .i_word9 (i_fill_word ^ TOP_BIT),
        .i_fill  (i_fill_word),
        .i_k     (k_word),
        .o_a     (a_flipped)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_round     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_beat) begin
                        r_state <= S_RUN;
                        r_round <= '0;
                    end
                end
                S_RUN: begin
                    if (!rounds_done) begin
                        r_round <= r_round + t_round'(1);
                    end else if (out_free) begin
                        r_state     <= S_IDLE;
                        r_a_plain   <= a_plain;
                        r_a_flipped <= a_flipped;
                        r_match     <= (a_plain == a_flipped);
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_a_plain   = r_a_plain;
    assign o_a_flipped = r_a_flipped;
    assign o_match     = r_match;

endmodule

// File: tb/tb_reduced_sha256_pair_check.sv
// Testbench for reduced_sha256_pair_check: drives word pairs over valid/ready, predicts both
// final a words of the 19-bit SHA-256 rounds and checks every result beat in order.
// Depends on rsc_pkg (port types) and the reduced_sha256_pair_check RTL.
`timescale 1ns / 1ps

module tb_reduced_sha256_pair_check;

    localparam int WB = $bits(rsc_pkg::t_word);
    localparam int NR = 57;

    // rotate/shift amounts, round(k*19/32) precomputed
    localparam int SH_S0A = 4;
    localparam int SH_S0B = 11;
    localparam int SH_S0C = 2;
    localparam int SH_S1A = 10;
    localparam int SH_S1B = 11;
    localparam int SH_S1C = 6;
    localparam int SH_E0A = 1;
    localparam int SH_E0B = 8;
    localparam int SH_E0C = 13;
    localparam int SH_E1A = 4;
    localparam int SH_E1B = 7;
    localparam int SH_E1C = 15;

    localparam rsc_pkg::t_word MSB      = {1'b1, {(WB-1){1'b0}}};
    localparam rsc_pkg::t_word ALL_ONES = {WB{1'b1}};

    localparam logic [31:0] SHA_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] SHA_IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    typedef struct {
        rsc_pkg::t_word first;
        rsc_pkg::t_word fill;
    } t_word_pair;

    typedef struct {
        rsc_pkg::t_word a_plain;
        rsc_pkg::t_word a_flipped;
        logic           match;
    } t_pair_result;

    logic           i_clk        = 1'b0;
    logic           i_rst_n      = 1'b0;
    logic           i_in_valid   = 1'b0;
    rsc_pkg::t_word i_first_word = '0;
    rsc_pkg::t_word i_fill_word  = '0;
    logic           i_out_ready  = 1'b0;
    logic           o_in_ready;
    logic           o_out_valid;
    rsc_pkg::t_word o_a_plain;
    rsc_pkg::t_word o_a_flipped;
    logic           o_match;

    t_word_pair   pending_pairs[$];
    t_pair_result expected_digests[$];
    t_word_pair   next_pair;
    t_pair_result head_digest;
    int           idle_pct    = 0;
    int           stall_pct   = 0;
    int           error_count = 0;

    reduced_sha256_pair_check u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_first_word(i_first_word),
        .i_fill_word (i_fill_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_a_plain   (o_a_plain),
        .o_a_flipped (o_a_flipped),
        .o_match     (o_match)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic rsc_pkg::t_word ror_word(input rsc_pkg::t_word x, input int k);
        logic [2*WB-1:0] dbl;
        dbl = {x, x} >> k;
        return dbl[WB-1:0];
    endfunction

    function automatic rsc_pkg::t_word final_a_word(input rsc_pkg::t_word first,
                                                    input rsc_pkg::t_word fill,
                                                    input bit flip);
        rsc_pkg::t_word w[64];
        rsc_pkg::t_word a, b, c, d, e, f, g, h;
        rsc_pkg::t_word x2, x15, sig0, sig1, t1, t2;
        int i;
        for (i = 0; i < 16; i++) begin
            w[i] = fill;
        end
        w[0] = first;
        if (flip) begin
            w[0] = first ^ MSB;
            w[9] = fill ^ MSB;
        end
        for (i = 16; i < NR; i++) begin
            x2   = w[i-2];
            x15  = w[i-15];
            sig1 = ror_word(x2, SH_S1A) ^ ror_word(x2, SH_S1B) ^ (x2 >> SH_S1C);
            sig0 = ror_word(x15, SH_S0A) ^ ror_word(x15, SH_S0B) ^ (x15 >> SH_S0C);
            w[i] = sig1 + w[i-7] + sig0 + w[i-16];
        end
        a = SHA_IV[0][WB-1:0];
        b = SHA_IV[1][WB-1:0];
        c = SHA_IV[2][WB-1:0];
        d = SHA_IV[3][WB-1:0];
        e = SHA_IV[4][WB-1:0];
        f = SHA_IV[5][WB-1:0];
        g = SHA_IV[6][WB-1:0];
        h = SHA_IV[7][WB-1:0];
        for (i = 0; i < NR; i++) begin
            t1 = h + (ror_word(e, SH_E1A) ^ ror_word(e, SH_E1B) ^ ror_word(e, SH_E1C))
                   + ((e & f) ^ (~e & g)) + SHA_K[i][WB-1:0] + w[i];
            t2 = (ror_word(a, SH_E0A) ^ ror_word(a, SH_E0B) ^ ror_word(a, SH_E0C))
                   + ((a & b) ^ (a & c) ^ (b & c));
            h = g;
            g = f;
            f = e;
            e = d + t1;
            d = c;
            c = b;
            b = a;
            a = t1 + t2;
        end
        return a;
    endfunction

    function automatic t_pair_result predict_pair(input rsc_pkg::t_word first,
                                                  input rsc_pkg::t_word fill);
        t_pair_result r;
        r.a_plain   = final_a_word(first, fill, 1'b0);
        r.a_flipped = final_a_word(first, fill, 1'b1);
        r.match     = (r.a_plain == r.a_flipped);
        return r;
    endfunction

    // driver: one beat per accept, gaps drawn per cycle
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                expected_digests.push_back(predict_pair(i_first_word, i_fill_word));
            end
            if (!i_in_valid || o_in_ready) begin
                if (pending_pairs.size() > 0 && $urandom_range(99) >= idle_pct) begin
                    next_pair = pending_pairs.pop_front();
                    i_in_valid   <= 1'b1;
                    i_first_word <= next_pair.first;
                    i_fill_word  <= next_pair.fill;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_digests.size() == 0) begin
                $error("result beat with nothing expected: a_plain=%h a_flipped=%h match=%b",
                       o_a_plain, o_a_flipped, o_match);
                error_count++;
            end else begin
                head_digest = expected_digests.pop_front();
                if (o_a_plain !== head_digest.a_plain) begin
                    $error("a_plain: expected %h, got %h", head_digest.a_plain, o_a_plain);
                    error_count++;
                end
                if (o_a_flipped !== head_digest.a_flipped) begin
                    $error("a_flipped: expected %h, got %h", head_digest.a_flipped,
                           o_a_flipped);
                    error_count++;
                end
                if (o_match !== head_digest.match) begin
                    $error("match: expected %b, got %b", head_digest.match, o_match);
                    error_count++;
                end
            end
        end
        i_out_ready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic add_pair(input rsc_pkg::t_word first, input rsc_pkg::t_word fill);
        t_word_pair p;
        p.first = first;
        p.fill  = fill;
        pending_pairs.push_back(p);
    endtask

    task automatic add_random_pairs(input int count);
        rsc_pkg::t_word x, y;
        int n;
        for (n = 0; n < count; n++) begin
            x = rsc_pkg::t_word'($urandom);
            y = rsc_pkg::t_word'($urandom);
            case ($urandom_range(9))
                0: y = rsc_pkg::t_word'(1) << $urandom_range(WB-1);
                1: y = ALL_ONES ^ (rsc_pkg::t_word'(1) << $urandom_range(WB-1));
                2: x = y;
                3: x = y ^ MSB;
                default: ;
            endcase
            add_pair(x, y);
        end
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        while (pending_pairs.size() != 0 || i_in_valid || expected_digests.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        add_pair('0, '0);
        add_pair(ALL_ONES, ALL_ONES);
        add_pair('0, ALL_ONES);
        add_pair(ALL_ONES, '0);
        add_pair(MSB, '0);
        add_pair('0, MSB);
        add_pair(MSB, MSB);
        add_pair(rsc_pkg::t_word'(1), rsc_pkg::t_word'(1));
        add_pair(rsc_pkg::t_word'(1), '0);
        add_pair('0, rsc_pkg::t_word'(1));
        add_pair(rsc_pkg::t_word'(32'h5555_5555), rsc_pkg::t_word'(32'haaaa_aaaa));
        add_pair(rsc_pkg::t_word'(32'haaaa_aaaa), rsc_pkg::t_word'(32'h5555_5555));
        add_pair(ALL_ONES ^ MSB, ALL_ONES ^ MSB);
        add_pair(rsc_pkg::t_word'(32'h0001_2345), rsc_pkg::t_word'(32'h0001_2345) ^ MSB);
        wait_drained();

        add_random_pairs(340);
        wait_drained();

        idle_pct = 75;
        add_random_pairs(340);
        wait_drained();

        idle_pct  = 0;
        stall_pct = 75;
        add_random_pairs(340);
        wait_drained();

        idle_pct  = 8;
        stall_pct = 8;
        add_random_pairs(330);
        wait_drained();

        repeat (70) @(posedge i_clk);
        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #(64'd10_000_000);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
